FILE: sv/mpcu_pkg.sv
package mpcu_pkg;

    localparam int MASK_BITS         = 32;
    localparam int CHAN_BITS         = 8;
    localparam int LANES             = 4;
    localparam int PIX_BYTES_MAX     = 4;
    localparam int DEFAULT_WORD_BITS = 32;
    localparam int SHIFT_BITS        = $clog2(MASK_BITS);
    localparam int RUN_BITS          = SHIFT_BITS + 1;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int COUNT_BITS        = 3;

    typedef logic [MASK_BITS-1:0]      mask_t;
    typedef logic [CHAN_BITS-1:0]      chan_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Register indexes of the configuration port
    localparam cfg_index_t REG_RED_MASK      = 3'd0;
    localparam cfg_index_t REG_GREEN_MASK    = 3'd1;
    localparam cfg_index_t REG_BLUE_MASK     = 3'd2;
    localparam cfg_index_t REG_ALPHA_MASK    = 3'd3;
    localparam cfg_index_t REG_ALPHA_PRESENT = 3'd4;
    localparam cfg_index_t REG_PIXEL_BYTES   = 3'd5;

    localparam count_t COUNT_ONE   = 3'd1;
    localparam count_t COUNT_TWO   = 3'd2;
    localparam count_t COUNT_THREE = 3'd3;
    localparam count_t COUNT_FOUR  = 3'd4;

    typedef struct packed {
        mask_t      red_mask;
        mask_t      green_mask;
        mask_t      blue_mask;
        mask_t      alpha_mask;
        logic       alpha_present;
        logic [2:0] pixel_bytes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        red_mask:      32'h0000_00FF,
        green_mask:    32'h0000_FF00,
        blue_mask:     32'h00FF_0000,
        alpha_mask:    32'hFF00_0000,
        alpha_present: 1'b1,
        pixel_bytes:   3'd4
    };

    // Pipeline stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Trailing-zero count by halving; an all-zero word gives MASK_BITS
    function automatic logic [RUN_BITS-1:0] trailing_zeros(input mask_t x);
        mask_t               v;
        logic [RUN_BITS-1:0] n;
        v = x;
        n = '0;
        if (x == '0) begin
            n = RUN_BITS'(MASK_BITS);
        end else begin
            for (int k = SHIFT_BITS - 1; k >= 0; k--) begin
                if ((v & ((mask_t'(1) << (1 << k)) - mask_t'(1))) == '0) begin
                    n = n + RUN_BITS'(1 << k);
                    v = v >> (1 << k);
                end
            end
        end
        return n;
    endfunction

endpackage

FILE: sv/mpcu_cfg.sv
module mpcu_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  mpcu_pkg::cfg_index_t       cfg_index,
    input  logic [mpcu_pkg::MASK_BITS-1:0] cfg_data,
    output mpcu_pkg::cfg_t             cfg
);
    import mpcu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_RED_MASK:      cfg_next.red_mask      = cfg_data;
                REG_GREEN_MASK:    cfg_next.green_mask    = cfg_data;
                REG_BLUE_MASK:     cfg_next.blue_mask     = cfg_data;
                REG_ALPHA_MASK:    cfg_next.alpha_mask    = cfg_data;
                REG_ALPHA_PRESENT: cfg_next.alpha_present = cfg_data[0];
                REG_PIXEL_BYTES:   cfg_next.pixel_bytes   = cfg_data[2:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/mpcu_lane.sv
module mpcu_lane (
    input  logic                  aclk,
    input  mpcu_pkg::stage_en_t   en,
    input  mpcu_pkg::mask_t       pix,
    input  mpcu_pkg::mask_t       mask,
    output mpcu_pkg::chan_t       chan
);
    import mpcu_pkg::*;

    // Stage 1: masked value, run start and run end
    mask_t                 val_reg;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [RUN_BITS-1:0]   end_reg;
    logic                  zero1_reg;
    logic [RUN_BITS-1:0]   shift_next;
    logic [RUN_BITS-1:0]   end_next;

    // Stage 2: aligned value and run length
    mask_t                 c_reg;
    logic [RUN_BITS-1:0]   size_reg;
    logic                  zero2_reg;
    mask_t                 c_next;
    logic [RUN_BITS-1:0]   size_next;

    // Stage 3: replicated or truncated channel
    chan_t                 chan_reg;
    chan_t                 chan_next;

    always_comb begin
        shift_next = trailing_zeros(mask);
        // Fill the trailing zeros, then the first zero above is the end of the run
        end_next   = trailing_zeros(~(mask | (mask - mask_t'(1))));
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            val_reg   <= pix & mask;
            shift_reg <= shift_next[SHIFT_BITS-1:0];
            end_reg   <= end_next;
            zero1_reg <= (mask == '0);
        end
    end

    always_comb begin
        c_next    = val_reg >> shift_reg;
        size_next = end_reg - {1'b0, shift_reg};
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            c_reg     <= c_next;
            size_reg  <= size_next;
            zero2_reg <= zero1_reg;
        end
    end

    // Copy j lands at bit offset CHAN_BITS - j*size; copies continue while the
    // previous one still left room, the last may shift right
    always_comb begin
        logic [8:0] size9;
        logic [8:0] prod;
        logic [8:0] prev;
        chan_t      acc;
        size9 = 9'(size_reg);
        acc   = '0;
        for (int j = 1; j <= CHAN_BITS; j++) begin
            prod = 9'(j) * size9;
            prev = prod - size9;
            if (prev < 9'(CHAN_BITS)) begin
                if (prod < 9'(CHAN_BITS)) begin
                    acc = acc | chan_t'(c_reg[CHAN_BITS-1:0] << (9'(CHAN_BITS) - prod));
                end else begin
                    acc = acc | chan_t'(c_reg >> (prod - 9'(CHAN_BITS)));
                end
            end
        end
        chan_next = zero2_reg ? '0 : acc;
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

FILE: sv/masked_pixel_channel_unpack.sv
// Throughput: one pixel per cycle; each of the four channel lanes is a
// three-stage pipeline (mask/run search, align, replicate) and stalls only on m_ready.
// Reset (aresetn low, synchronous): pipeline valids clear, the masks return to
// 0xFF/0xFF00/0xFF0000/0xFF000000, alpha_present to 1 and pixel_bytes to 4.
module masked_pixel_channel_unpack #(
    parameter int WORD_BITS = mpcu_pkg::DEFAULT_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [WORD_BITS-1:0]           s_pixel_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mpcu_pkg::chan_t                m_channel_zero,
    output mpcu_pkg::chan_t                m_channel_one,
    output mpcu_pkg::chan_t                m_channel_two,
    output mpcu_pkg::chan_t                m_channel_three,
    output mpcu_pkg::count_t               m_component_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  mpcu_pkg::cfg_index_t           cfg_index,
    input  logic [mpcu_pkg::MASK_BITS-1:0] cfg_data
);
    import mpcu_pkg::*;

    cfg_t      cfg;
    stage_en_t en;
    mask_t     pix_full;
    mask_t     pix_gated;
    count_t    count;
    mask_t     lane_mask [LANES];
    chan_t     lane_chan [LANES];

    logic      v1_reg, v2_reg, v3_reg;
    logic      v1_next, v2_next, v3_next;
    count_t    cnt1_reg, cnt2_reg, cnt3_reg;

    mpcu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage loads when it is empty or its beat moves on
    always_comb begin
        en.s3 = !v3_reg || m_ready;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign s_ready = en.s1;

    always_comb begin
        v1_next = en.s1 ? s_valid : v1_reg;
        v2_next = en.s2 ? v1_reg  : v2_reg;
        v3_next = en.s3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Drop bytes above the configured pixel size
    always_comb begin
        pix_full = MASK_BITS'(s_pixel_word);
        for (int b = 0; b < PIX_BYTES_MAX; b++) begin
            pix_gated[b*8 +: 8] = (cfg.pixel_bytes > 3'(b)) ? pix_full[b*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        if (cfg.red_mask != '0 && cfg.green_mask != '0 && cfg.blue_mask != '0) begin
            count = cfg.alpha_present ? COUNT_FOUR : COUNT_THREE;
        end else if (cfg.red_mask != '0 && cfg.green_mask != '0) begin
            count = COUNT_TWO;
        end else begin
            count = COUNT_ONE;
        end
    end

    // Unused lanes see an empty mask and so give zero
    always_comb begin
        lane_mask[0] = (count == COUNT_ONE && cfg.alpha_mask != '0) ? cfg.alpha_mask
                                                                    : cfg.red_mask;
        lane_mask[1] = (count >= COUNT_TWO)   ? cfg.green_mask : '0;
        lane_mask[2] = (count >= COUNT_THREE) ? cfg.blue_mask  : '0;
        lane_mask[3] = (count == COUNT_FOUR)  ? cfg.alpha_mask : '0;
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        mpcu_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .pix  (pix_gated),
            .mask (lane_mask[i]),
            .chan (lane_chan[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            cnt1_reg <= count;
        end
        if (en.s2) begin
            cnt2_reg <= cnt1_reg;
        end
        if (en.s3) begin
            cnt3_reg <= cnt2_reg;
        end
    end

    assign m_valid           = v3_reg;
    assign m_channel_zero    = lane_chan[0];
    assign m_channel_one     = lane_chan[1];
    assign m_channel_two     = lane_chan[2];
    assign m_channel_three   = lane_chan[3];
    assign m_component_count = cnt3_reg;

    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full and stalled");

    a_accept_fills_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted beat did not enter stage 1");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_component_count == COUNT_ONE || m_component_count == COUNT_TWO ||
                     m_component_count == COUNT_THREE || m_component_count == COUNT_FOUR))
        else $error("component count out of range");

    a_unused_alpha_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_component_count != COUNT_FOUR) |-> (m_channel_three == '0))
        else $error("unused fourth channel not zero");

    a_single_channel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_component_count == COUNT_ONE) |->
            (m_channel_one == '0 && m_channel_two == '0))
        else $error("unused channels not zero with one component");

endmodule

FILE: tb/sv/pixel_unpack_checker.sv
module pixel_unpack_checker #(
    parameter int WORD_BITS = mpcu_pkg::DEFAULT_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [WORD_BITS-1:0]           s_pixel_word,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  mpcu_pkg::chan_t                m_channel_zero,
    input  mpcu_pkg::chan_t                m_channel_one,
    input  mpcu_pkg::chan_t                m_channel_two,
    input  mpcu_pkg::chan_t                m_channel_three,
    input  mpcu_pkg::count_t               m_component_count,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  mpcu_pkg::cfg_index_t           cfg_index,
    input  logic [mpcu_pkg::MASK_BITS-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mpcu_pkg::*;

    typedef struct packed {
        chan_t  channel_zero;
        chan_t  channel_one;
        chan_t  channel_two;
        chan_t  channel_three;
        count_t component_count;
    } rgba_pixel_t;

    cfg_t        fmt;
    rgba_pixel_t expected_pixels[$];

    // Pull one channel through its mask and stretch or cut it to 8 bits.
    function automatic chan_t extract_channel(mask_t pix, mask_t m);
        mask_t t;
        mask_t c;
        mask_t acc;
        int    shift;
        int    size;
        int    outb;
        if (m == '0) begin
            return '0;
        end
        t     = m;
        shift = 0;
        size  = 0;
        while (t[0] == 1'b0) begin
            shift++;
            t = t >> 1;
        end
        while (t[0] == 1'b1) begin
            size++;
            t = t >> 1;
        end
        c    = (pix & m) >> shift;
        acc  = '0;
        outb = CHAN_BITS;
        // replicate narrow fields from the top down
        while (size < outb) begin
            acc  = acc | (c << (outb - size));
            outb = outb - size;
        end
        acc = acc | (c >> (size - outb));
        return acc[CHAN_BITS-1:0];
    endfunction

    function automatic rgba_pixel_t unpack_pixel(logic [WORD_BITS-1:0] word, cfg_t f);
        rgba_pixel_t r;
        mask_t       pix;
        mask_t       lane_mask[LANES];
        chan_t       lane_val[LANES];
        logic [63:0] keep;
        int          nbytes;
        count_t      count;
        nbytes = (f.pixel_bytes > PIX_BYTES_MAX) ? PIX_BYTES_MAX : int'(f.pixel_bytes);
        keep   = (64'd1 << (nbytes * 8)) - 64'd1;
        pix    = mask_t'(word) & keep[MASK_BITS-1:0];
        if (f.red_mask != '0 && f.green_mask != '0 && f.blue_mask != '0) begin
            count = f.alpha_present ? COUNT_FOUR : COUNT_THREE;
        end else if (f.red_mask != '0 && f.green_mask != '0) begin
            count = COUNT_TWO;
        end else begin
            count = COUNT_ONE;
        end
        lane_mask[0] = f.red_mask;
        lane_mask[1] = f.green_mask;
        lane_mask[2] = f.blue_mask;
        lane_mask[3] = f.alpha_mask;
        // a lone component with an alpha mask is alpha
        if (count == COUNT_ONE && f.alpha_mask != '0) begin
            lane_mask[0] = f.alpha_mask;
        end
        for (int k = 0; k < LANES; k++) begin
            lane_val[k] = (k < int'(count)) ? extract_channel(pix, lane_mask[k]) : '0;
        end
        r.channel_zero    = lane_val[0];
        r.channel_one     = lane_val[1];
        r.channel_two     = lane_val[2];
        r.channel_three   = lane_val[3];
        r.component_count = count;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        rgba_pixel_t want;
        if (!aresetn) begin
            fmt = CFG_RESET;
            expected_pixels.delete();
            fail_count = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result beat with no pixel pending");
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("channel_zero", want.channel_zero, m_channel_zero);
                    check_field("channel_one", want.channel_one, m_channel_one);
                    check_field("channel_two", want.channel_two, m_channel_two);
                    check_field("channel_three", want.channel_three, m_channel_three);
                    check_field("component_count", want.component_count,
                                m_component_count);
                end
            end
            // a beat taken on the same edge as a write still sees the old format
            if (s_valid && s_ready) begin
                expected_pixels.push_back(unpack_pixel(s_pixel_word, fmt));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RED_MASK: begin
                        fmt.red_mask = cfg_data;
                    end
                    REG_GREEN_MASK: begin
                        fmt.green_mask = cfg_data;
                    end
                    REG_BLUE_MASK: begin
                        fmt.blue_mask = cfg_data;
                    end
                    REG_ALPHA_MASK: begin
                        fmt.alpha_mask = cfg_data;
                    end
                    REG_ALPHA_PRESENT: begin
                        fmt.alpha_present = cfg_data[0];
                    end
                    REG_PIXEL_BYTES: begin
                        fmt.pixel_bytes = cfg_data[2:0];
                    end
                    default: begin
                    end
                endcase
            end
            outstanding <= expected_pixels.size();
        end
    end

endmodule

FILE: tb/sv/tb_masked_pixel_channel_unpack.sv
module tb_masked_pixel_channel_unpack;
    timeunit 1ns;
    timeprecision 1ps;

    import mpcu_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 50;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [31:0]          s_pixel_word;
    logic                 m_valid;
    logic                 m_ready;
    chan_t                m_channel_zero;
    chan_t                m_channel_one;
    chan_t                m_channel_two;
    chan_t                m_channel_three;
    count_t               m_component_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_index_t           cfg_index;
    logic [MASK_BITS-1:0] cfg_data;
    int                   fail_count;
    int                   outstanding;

    bit steady       = 1'b0;
    bit hold_results = 1'b0;

    masked_pixel_channel_unpack dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_word      (s_pixel_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel_zero    (m_channel_zero),
        .m_channel_one     (m_channel_one),
        .m_channel_two     (m_channel_two),
        .m_channel_three   (m_channel_three),
        .m_component_count (m_component_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    pixel_unpack_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_word      (s_pixel_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel_zero    (m_channel_zero),
        .m_channel_one     (m_channel_one),
        .m_channel_two     (m_channel_two),
        .m_channel_three   (m_channel_three),
        .m_component_count (m_component_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random back-pressure, or a long hold when asked.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 11);
                @(posedge aclk);
            end
        end
    end

    function automatic mask_t random_mask();
        int          kind;
        int          len;
        int          lo;
        logic [63:0] run;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return $urandom;
            end
            default: begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32)
                                                  : $urandom_range(1, 10);
                lo  = $urandom_range(0, 32 - len);
                run = ((64'd1 << len) - 64'd1) << lo;
                return run[MASK_BITS-1:0];
            end
        endcase
    endfunction

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic send_pixel(logic [31:0] word);
        if (!steady && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel_word <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering pixels and wait until every result is out.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic apply_format(mask_t red, mask_t green, mask_t blue, mask_t alpha,
                                logic alpha_on, logic [2:0] nbytes);
        cfg_index_t           regs[6];
        logic [MASK_BITS-1:0] vals[6];
        logic [MASK_BITS-1:0] noise;
        noise   = $urandom;
        regs[0] = REG_RED_MASK;
        regs[1] = REG_GREEN_MASK;
        regs[2] = REG_BLUE_MASK;
        regs[3] = REG_ALPHA_MASK;
        regs[4] = REG_ALPHA_PRESENT;
        regs[5] = REG_PIXEL_BYTES;
        vals[0] = red;
        vals[1] = green;
        vals[2] = blue;
        vals[3] = alpha;
        // upper bits of the narrow registers carry junk
        vals[4] = {noise[MASK_BITS-1:1], alpha_on};
        vals[5] = {noise[MASK_BITS-1:3], nbytes};
        for (int k = 0; k < 6; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic directed_pixels();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hA5C3_3C5A);
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_pixel_word <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_RED_MASK;
        cfg_data     <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset format: plain 8-bit RGBA
        send_pixel(32'h1234_5678);
        directed_pixels();

        // 565 without alpha, two bytes
        drain();
        apply_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, '0, 1'b0, 3'd2);
        directed_pixels();

        // one-bit channels, byte count above four
        drain();
        apply_format(32'h1, 32'h2, 32'h4, 32'h8, 1'b1, 3'd7);
        directed_pixels();

        // single full-width channel
        drain();
        apply_format('1, '0, '0, '0, 1'b1, 3'd4);
        directed_pixels();

        // alpha only
        drain();
        apply_format('0, '0, '0, 32'hFF00_0000, 1'b1, 3'd4);
        directed_pixels();

        // red and green only
        drain();
        apply_format(32'h0000_000F, 32'h0000_00F0, '0, 32'h0000_0F00, 1'b1, 3'd1);
        directed_pixels();

        // scattered masks, zero byte count
        drain();
        apply_format(32'h0000_0F0F, 32'h8000_0001, 32'h00F0_00F0, 32'hAAAA_AAAA,
                     1'b0, 3'd0);
        directed_pixels();

        // no masks at all
        drain();
        apply_format('0, '0, '0, '0, 1'b0, 3'd4);
        directed_pixels();

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            apply_format(random_mask(), random_mask(), random_mask(), random_mask(),
                         1'(($urandom_range(0, 1))),
                         ($urandom_range(0, 2) == 0) ? 3'(($urandom_range(0, 7)))
                                                     : 3'd4);
            steady = (ph == 4) || (ph == 9);
            if (ph == 9) begin
                hold_results = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 12 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                send_pixel(random_pixel());
            end
            steady = 1'b0;
        end

        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mpcu_pkg.sv
sv/mpcu_cfg.sv
sv/mpcu_lane.sv
sv/masked_pixel_channel_unpack.sv
tb/sv/pixel_unpack_checker.sv
tb/sv/tb_masked_pixel_channel_unpack.sv
